### rtl/dars_pkg.sv
// Shared types, constants and the sine table of the delta arm angle search.
`timescale 1ns / 1ps
`default_nettype none
package dars_pkg;

   // Fixed-point format of the sine table
   localparam int TRIG_FRAC_BITS = 14;
   localparam int HI_FRAC        = 30;
   localparam int SIN_W          = TRIG_FRAC_BITS + 1;
   localparam int LUT_LAST       = 90;

   typedef logic [SIN_W-1:0] sin_lut_type [0:LUT_LAST];

   // Register map, one word per register
   typedef enum logic [2:0] {
      REG_UPPER_ARM_LEN   = 3'd0,
      REG_LOWER_ARM_LEN   = 3'd1,
      REG_BASE_RADIUS     = 3'd2,
      REG_EFFECTOR_RADIUS = 3'd3,
      REG_START_ANGLE     = 3'd4,
      REG_END_ANGLE       = 3'd5,
      REG_BASE_MARGIN     = 3'd6,
      REG_SERVO_OFFSET    = 3'd7
   } dars_reg_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic              load_target;
      logic              load_arm;
      logic              issue;
      logic              issue_last;
      logic signed [7:0] issue_angle;
      logic              record;
      logic              record_hit;
      logic              publish;
      logic [1:0]        arm;
   } dars_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic busy;
      logic res_valid;
      logic res_hit;
      logic res_last;
   } dars_status_type;

   // Divide one Taylor term by (2k)(2k+1)
   function automatic longint taylor_div(input longint term, input int k);
      longint q;
      unique case (k)
         1:  q = term / 6;
         2:  q = term / 20;
         3:  q = term / 42;
         4:  q = term / 72;
         5:  q = term / 110;
         6:  q = term / 156;
         7:  q = term / 210;
         8:  q = term / 272;
         9:  q = term / 342;
         10: q = term / 420;
         11: q = term / 506;
         12: q = term / 600;
         13: q = term / 702;
         14: q = term / 812;
         15: q = term / 930;
         16: q = term / 1056;
         17: q = term / 1190;
         18: q = term / 1332;
         19: q = term / 1482;
         20: q = term / 1640;
         21: q = term / 1806;
         22: q = term / 1980;
         23: q = term / 2162;
         default: q = term;
      endcase
      return q;
   endfunction

   // Build the quarter-wave sine table from a series at 30 fraction bits
   function automatic sin_lut_type build_sin_lut();
      sin_lut_type lut;
      longint      x;
      longint      term;
      longint      sum;
      for (int d = 0; d <= LUT_LAST; d++) begin
         x    = (longint'(d) * 64'sd3373259426 + 64'sd90) / 180;
         term = x;
         sum  = x;
         for (int k = 1; k < 24; k++) begin
            if (term != 0) begin
               term = (term * x) >>> HI_FRAC;
               term = (term * x) >>> HI_FRAC;
               term = taylor_div(term, k);
               if ((k % 2) == 1) sum = sum - term;
               else sum = sum + term;
            end
         end
         if (sum < 0) sum = 0;
         if (sum > (64'sd1 <<< HI_FRAC)) sum = 64'sd1 <<< HI_FRAC;
         lut[d] = SIN_W'((sum + (64'sd1 <<< (HI_FRAC - TRIG_FRAC_BITS - 1)))
                         >>> (HI_FRAC - TRIG_FRAC_BITS));
      end
      return lut;
   endfunction

   localparam sin_lut_type SIN_LUT = build_sin_lut();

   localparam logic signed [15:0] SIN_ONE = 16'sd1 <<< TRIG_FRAC_BITS;
   localparam logic signed [15:0] SIN30   = $signed({1'b0, SIN_LUT[30]});
   localparam logic signed [15:0] SIN60   = $signed({1'b0, SIN_LUT[60]});

   // Sine of any angle in -128..217 degrees through the quadrant symmetries
   function automatic logic signed [15:0] sin_deg(input logic signed [9:0] ang);
      logic [9:0] r;
      logic [6:0] idx;
      logic       neg;
      r = ang[9] ? 10'(ang + 10'sd360) : 10'(ang);
      priority if (r <= 10'd90) begin
         idx = 7'(r);
         neg = 1'b0;
      end else if (r <= 10'd180) begin
         idx = 7'(10'd180 - r);
         neg = 1'b0;
      end else if (r <= 10'd270) begin
         idx = 7'(r - 10'd180);
         neg = 1'b1;
      end else begin
         idx = 7'(10'd360 - r);
         neg = 1'b1;
      end
      return neg ? -$signed({1'b0, SIN_LUT[idx]}) : $signed({1'b0, SIN_LUT[idx]});
   endfunction

endpackage
`default_nettype wire

### rtl/dars_datapath.sv
// Datapath: arm setup, four-stage distance pipeline, per-arm results and output register.
`timescale 1ns / 1ps
`default_nettype none
module dars_datapath #(
   parameter int NUM_PASSES = 4
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire dars_pkg::dars_cmd_type    cmd,
   input  wire logic [((NUM_PASSES > 1) ? $clog2(NUM_PASSES) : 1)-1:0] issue_pass,
   output dars_pkg::dars_status_type      status,
   input  wire logic signed [10:0]        target_x,
   input  wire logic signed [10:0]        target_y,
   input  wire logic signed [10:0]        target_z,
   input  wire logic [7:0]                upper_arm_len,
   input  wire logic [8:0]                lower_arm_len,
   input  wire logic [7:0]                base_radius,
   input  wire logic [7:0]                effector_radius,
   input  wire logic [3:0]                base_margin,
   input  wire logic [7:0]                servo_offset,
   output logic signed [7:0]              angle_arm1,
   output logic signed [7:0]              angle_arm2,
   output logic signed [7:0]              angle_arm3,
   output logic                           found_arm1,
   output logic                           found_arm2,
   output logic                           found_arm3,
   output logic [7:0]                     servo_cmd1,
   output logic [7:0]                     servo_cmd2,
   output logic [7:0]                     servo_cmd3
);
   localparam int F      = dars_pkg::TRIG_FRAC_BITS;
   localparam logic signed [25:0] RND1 = (26'sd1 <<< F) - 26'sd1;
   localparam logic signed [40:0] RND2 = (41'sd1 <<< (2 * F)) - 41'sd1;

   // Target latch
   logic signed [10:0] tx_ff, ty_ff, tz_ff;

   // Per-arm constants
   logic signed [12:0] px_ff, py_ff, px_in, py_in;
   logic signed [9:0]  sx_ff, sy_ff, sx_in, sy_in;
   logic signed [25:0] kx_ff, ky_ff, kx_in, ky_in;

   logic signed [15:0] ux, uy;
   logic signed [25:0] px_sum, py_sum, sx_sum, sy_sum;
   logic signed [25:0] px_adj, py_adj, sx_adj, sy_adj;

   // Pick the arm direction
   always_comb begin
      unique case (cmd.arm)
         2'd1: begin
            ux = -dars_pkg::SIN30;
            uy = dars_pkg::SIN60;
         end
         2'd2: begin
            ux = -dars_pkg::SIN30;
            uy = -dars_pkg::SIN60;
         end
         default: begin
            ux = dars_pkg::SIN_ONE;
            uy = 16'sd0;
         end
      endcase
   end

   // Shift the target by the effector joint, place the servo axis
   always_comb begin
      px_sum = (26'(tx_ff) <<< F) + 26'(ux) * 26'($signed({1'b0, effector_radius}));
      py_sum = (26'(ty_ff) <<< F) + 26'(uy) * 26'($signed({1'b0, effector_radius}));
      sx_sum = 26'(ux) * 26'($signed({1'b0, base_radius}));
      sy_sum = 26'(uy) * 26'($signed({1'b0, base_radius}));
      px_adj = px_sum + (px_sum[25] ? RND1 : 26'sd0);
      py_adj = py_sum + (py_sum[25] ? RND1 : 26'sd0);
      sx_adj = sx_sum + (sx_sum[25] ? RND1 : 26'sd0);
      sy_adj = sy_sum + (sy_sum[25] ? RND1 : 26'sd0);
      px_in  = 13'(px_adj >>> F);
      py_in  = 13'(py_adj >>> F);
      sx_in  = 10'(sx_adj >>> F);
      sy_in  = 10'(sy_adj >>> F);
      kx_in  = 26'(ux) * 26'($signed({1'b0, upper_arm_len}));
      ky_in  = 26'(uy) * 26'($signed({1'b0, upper_arm_len}));
   end

   always_ff @(posedge clock) begin
      if (cmd.load_target) begin
         tx_ff <= target_x;
         ty_ff <= target_y;
         tz_ff <= target_z;
      end
      if (cmd.load_arm) begin
         px_ff <= px_in;
         py_ff <= py_in;
         sx_ff <= sx_in;
         sy_ff <= sy_in;
         kx_ff <= kx_in;
         ky_ff <= ky_in;
      end
   end

   // Stage 1: trig lookup, elbow products, tolerance window squares
   logic signed [9:0]  ang10;
   logic signed [15:0] cos_v, sin_v;
   logic [4:0]         m5;
   logic signed [10:0] lo;
   logic [9:0]         hi1;
   logic               s1_valid_ff, s1_last_ff, s1_lo_pos_ff;
   logic signed [7:0]  s1_angle_ff;
   logic signed [39:0] s1_mx_ff, s1_my_ff, s1_mx_in, s1_my_in;
   logic signed [25:0] s1_mz_ff, s1_mz_in;
   logic [19:0]        s1_lo_sq_ff, s1_hi_sq_ff, s1_lo_sq_in, s1_hi_sq_in;

   always_comb begin
      ang10       = 10'(cmd.issue_angle);
      cos_v       = dars_pkg::sin_deg(ang10 + 10'sd90);
      sin_v       = dars_pkg::sin_deg(ang10);
      s1_mx_in    = 40'(kx_ff) * 40'(cos_v);
      s1_my_in    = 40'(ky_ff) * 40'(cos_v);
      s1_mz_in    = 26'($signed({1'b0, upper_arm_len})) * 26'(sin_v);
      m5          = 5'(base_margin) + 5'(issue_pass);
      lo          = $signed(11'(lower_arm_len)) - $signed(11'(m5)) + 11'sd1;
      hi1         = 10'(lower_arm_len) + 10'(m5);
      s1_lo_sq_in = 20'(lo[9:0]) * 20'(lo[9:0]);
      s1_hi_sq_in = 20'(hi1) * 20'(hi1);
   end

   // Stage 2: elbow position and differences
   logic signed [40:0] ex_sum, ey_sum, ex_adj, ey_adj;
   logic signed [25:0] ez_adj;
   logic signed [10:0] ex, ey;
   logic signed [9:0]  ez;
   logic               s2_valid_ff, s2_last_ff, s2_lo_pos_ff;
   logic signed [7:0]  s2_angle_ff;
   logic signed [13:0] s2_dx_ff, s2_dy_ff, s2_dz_ff;
   logic [19:0]        s2_lo_sq_ff, s2_hi_sq_ff;

   always_comb begin
      ex_sum = (41'(sx_ff) <<< (2 * F)) + 41'(s1_mx_ff);
      ey_sum = (41'(sy_ff) <<< (2 * F)) + 41'(s1_my_ff);
      ex_adj = ex_sum + (ex_sum[40] ? RND2 : 41'sd0);
      ey_adj = ey_sum + (ey_sum[40] ? RND2 : 41'sd0);
      ez_adj = s1_mz_ff + (s1_mz_ff[25] ? RND1 : 26'sd0);
      ex     = 11'(ex_adj >>> (2 * F));
      ey     = 11'(ey_adj >>> (2 * F));
      ez     = 10'(ez_adj >>> F);
   end

   // Stage 3: squares
   logic               s3_valid_ff, s3_last_ff, s3_lo_pos_ff;
   logic signed [7:0]  s3_angle_ff;
   logic [27:0]        s3_sqx_ff, s3_sqy_ff, s3_sqz_ff;
   logic [19:0]        s3_lo_sq_ff, s3_hi_sq_ff;

   // Stage 4: distance window compare
   logic [29:0]        dist_sq;
   logic               hit_in;
   logic               res_valid_ff, res_hit_ff, res_last_ff;
   logic signed [7:0]  res_angle_ff;

   always_comb begin
      dist_sq = 30'(s3_sqx_ff) + 30'(s3_sqy_ff) + 30'(s3_sqz_ff);
      hit_in  = (!s3_lo_pos_ff || (dist_sq >= 30'(s3_lo_sq_ff)))
                && (dist_sq < 30'(s3_hi_sq_ff));
   end

   // Advance the valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= cmd.issue;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         res_valid_ff <= s3_valid_ff;
      end
   end

   // Advance the payload
   always_ff @(posedge clock) begin
      s1_angle_ff  <= cmd.issue_angle;
      s1_last_ff   <= cmd.issue_last;
      s1_lo_pos_ff <= (lo > 11'sd0);
      s1_mx_ff     <= s1_mx_in;
      s1_my_ff     <= s1_my_in;
      s1_mz_ff     <= s1_mz_in;
      s1_lo_sq_ff  <= s1_lo_sq_in;
      s1_hi_sq_ff  <= s1_hi_sq_in;

      s2_angle_ff  <= s1_angle_ff;
      s2_last_ff   <= s1_last_ff;
      s2_lo_pos_ff <= s1_lo_pos_ff;
      s2_dx_ff     <= 14'(px_ff) - 14'(ex);
      s2_dy_ff     <= 14'(py_ff) - 14'(ey);
      s2_dz_ff     <= 14'(tz_ff) - 14'(ez);
      s2_lo_sq_ff  <= s1_lo_sq_ff;
      s2_hi_sq_ff  <= s1_hi_sq_ff;

      s3_angle_ff  <= s2_angle_ff;
      s3_last_ff   <= s2_last_ff;
      s3_lo_pos_ff <= s2_lo_pos_ff;
      s3_sqx_ff    <= 28'(28'(s2_dx_ff) * 28'(s2_dx_ff));
      s3_sqy_ff    <= 28'(28'(s2_dy_ff) * 28'(s2_dy_ff));
      s3_sqz_ff    <= 28'(28'(s2_dz_ff) * 28'(s2_dz_ff));
      s3_lo_sq_ff  <= s2_lo_sq_ff;
      s3_hi_sq_ff  <= s2_hi_sq_ff;

      res_angle_ff <= s3_angle_ff;
      res_last_ff  <= s3_last_ff;
      res_hit_ff   <= hit_in;
   end

   always_comb begin
      status.busy      = s1_valid_ff | s2_valid_ff | s3_valid_ff | res_valid_ff;
      status.res_valid = res_valid_ff;
      status.res_hit   = res_hit_ff;
      status.res_last  = res_last_ff;
   end

   // Per-arm results
   logic signed [7:0] arm_ang_ff [3];
   logic              arm_hit_ff [3];
   logic signed [9:0] servo_diff [3];
   logic [7:0]        servo_sat [3];

   always_ff @(posedge clock) begin
      if (cmd.record) begin
         arm_ang_ff[cmd.arm] <= cmd.record_hit ? res_angle_ff : 8'sd0;
         arm_hit_ff[cmd.arm] <= cmd.record_hit;
      end
   end

   // Saturate offset minus angle to the servo range
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         servo_diff[i] = $signed({2'b00, servo_offset}) - 10'(arm_ang_ff[i]);
         if (servo_diff[i] < 10'sd0) servo_sat[i] = 8'd0;
         else if (servo_diff[i] > 10'sd180) servo_sat[i] = 8'd180;
         else servo_sat[i] = 8'(servo_diff[i]);
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         angle_arm1 <= arm_ang_ff[0];
         angle_arm2 <= arm_ang_ff[1];
         angle_arm3 <= arm_ang_ff[2];
         found_arm1 <= arm_hit_ff[0];
         found_arm2 <= arm_hit_ff[1];
         found_arm3 <= arm_hit_ff[2];
         servo_cmd1 <= servo_sat[0];
         servo_cmd2 <= servo_sat[1];
         servo_cmd3 <= servo_sat[2];
      end
   end

endmodule
`default_nettype wire

### rtl/dars_ctrl.sv
// Controller: sequences arms, passes and angles and runs both handshakes.
`timescale 1ns / 1ps
`default_nettype none
module dars_ctrl #(
   parameter int NUM_PASSES = 4
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   input  wire logic signed [7:0]         start_angle,
   input  wire logic signed [7:0]         end_angle,
   input  wire dars_pkg::dars_status_type status,
   output dars_pkg::dars_cmd_type         cmd,
   output logic [((NUM_PASSES > 1) ? $clog2(NUM_PASSES) : 1)-1:0] issue_pass
);
   localparam int PASS_W = (NUM_PASSES > 1) ? $clog2(NUM_PASSES) : 1;
   localparam logic [PASS_W-1:0] PASS_LAST = PASS_W'(NUM_PASSES - 1);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_PREP  = 6'b000010,
      ST_RUN   = 6'b000100,
      ST_DRAIN = 6'b001000,
      ST_NEXT  = 6'b010000,
      ST_PUB   = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   logic [1:0]        arm_ff, arm_in;
   logic signed [7:0] angle_ff, angle_in;
   logic [PASS_W-1:0] pass_ff, pass_in;
   logic              issue_on_ff, issue_on_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic signed [7:0] end_m1;
   logic              at_row_end, at_last;

   always_comb begin
      end_m1     = end_angle - 8'sd1;
      at_row_end = (angle_ff == end_m1);
      at_last    = at_row_end && (pass_ff == PASS_LAST);
   end

   always_comb begin
      state_in       = state_ff;
      arm_in         = arm_ff;
      angle_in       = angle_ff;
      pass_in        = pass_ff;
      issue_on_in    = issue_on_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      cmd            = '0;
      cmd.arm        = arm_ff;
      cmd.issue_angle = angle_ff;
      cmd.issue_last = at_last;
      req_stall      = (state_ff != ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_target = 1'b1;
               arm_in          = 2'd0;
               state_in        = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.load_arm = 1'b1;
            angle_in     = start_angle;
            pass_in      = '0;
            if (start_angle < end_angle) begin
               issue_on_in = 1'b1;
               state_in    = ST_RUN;
            end else begin
               cmd.record = 1'b1;
               state_in   = ST_NEXT;
            end
         end
         ST_RUN: begin
            // Issue one angle a cycle until the final one of the last pass or the first hit
            if (issue_on_ff) begin
               cmd.issue = 1'b1;
               if (at_last) begin
                  issue_on_in = 1'b0;
               end else if (at_row_end) begin
                  angle_in = start_angle;
                  pass_in  = pass_ff + PASS_W'(1);
               end else begin
                  angle_in = angle_ff + 8'sd1;
               end
            end
            // First hit wins; drop what is still in flight
            if (status.res_valid) begin
               if (status.res_hit) begin
                  cmd.record     = 1'b1;
                  cmd.record_hit = 1'b1;
                  issue_on_in    = 1'b0;
                  state_in       = ST_DRAIN;
               end else if (status.res_last) begin
                  cmd.record = 1'b1;
                  state_in   = ST_NEXT;
               end
            end
         end
         ST_DRAIN: begin
            if (!status.busy) state_in = ST_NEXT;
         end
         ST_NEXT: begin
            if (arm_ff == 2'd2) begin
               state_in = ST_PUB;
            end else begin
               arm_in   = arm_ff + 2'd1;
               state_in = ST_PREP;
            end
         end
         ST_PUB: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issue_on_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         arm_ff       <= 2'd0;
         pass_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         issue_on_ff  <= issue_on_in;
         rsp_valid_ff <= rsp_valid_in;
         arm_ff       <= arm_in;
         pass_ff      <= pass_in;
      end
   end

   always_ff @(posedge clock) begin
      angle_ff <= angle_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign issue_pass = pass_ff;

endmodule
`default_nettype wire

### rtl/delta_arm_angle_search.sv
// Top level: register port, controller and datapath of the delta arm angle search.
// Sequence: per arm a setup step, then one angle tried per cycle (up to passes times
// the angle span, ending early at the first hit) and the distance pipeline; arms run
// one after another, then the result is published.
// Throughput: one transaction at a time; requests stall until the controller is idle again.
// Reset (synchronous) returns the registers to their defaults and empties the pipeline.
`timescale 1ns / 1ps
`default_nettype none
module delta_arm_angle_search #(
   parameter int NUM_PASSES = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [10:0] req_target_x,
   input  wire logic signed [10:0] req_target_y,
   input  wire logic signed [10:0] req_target_z,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [7:0]       rsp_angle_arm1,
   output logic signed [7:0]       rsp_angle_arm2,
   output logic signed [7:0]       rsp_angle_arm3,
   output logic                    rsp_found_arm1,
   output logic                    rsp_found_arm2,
   output logic                    rsp_found_arm3,
   output logic [7:0]              rsp_servo_cmd1,
   output logic [7:0]              rsp_servo_cmd2,
   output logic [7:0]              rsp_servo_cmd3,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [4:0]         csr_paddr,
   input  wire logic [31:0]        csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);
   localparam int PASS_W = (NUM_PASSES > 1) ? $clog2(NUM_PASSES) : 1;

   logic [7:0]        upper_arm_len_ff;
   logic [8:0]        lower_arm_len_ff;
   logic [7:0]        base_radius_ff;
   logic [7:0]        effector_radius_ff;
   logic signed [7:0] start_angle_ff;
   logic signed [7:0] end_angle_ff;
   logic [3:0]        base_margin_ff;
   logic [7:0]        servo_offset_ff;

   logic                   csr_wr;
   dars_pkg::dars_reg_type csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = dars_pkg::dars_reg_type'(csr_paddr[4:2]);

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         upper_arm_len_ff   <= 8'd50;
         lower_arm_len_ff   <= 9'd210;
         base_radius_ff     <= 8'd100;
         effector_radius_ff <= 8'd35;
         start_angle_ff     <= -8'sd30;
         end_angle_ff       <= 8'sd80;
         base_margin_ff     <= 4'd1;
         servo_offset_ff    <= 8'd105;
      end else if (csr_wr) begin
         unique case (csr_idx)
            dars_pkg::REG_UPPER_ARM_LEN:   upper_arm_len_ff   <= csr_pwdata[7:0];
            dars_pkg::REG_LOWER_ARM_LEN:   lower_arm_len_ff   <= csr_pwdata[8:0];
            dars_pkg::REG_BASE_RADIUS:     base_radius_ff     <= csr_pwdata[7:0];
            dars_pkg::REG_EFFECTOR_RADIUS: effector_radius_ff <= csr_pwdata[7:0];
            dars_pkg::REG_START_ANGLE:     start_angle_ff     <= csr_pwdata[7:0];
            dars_pkg::REG_END_ANGLE:       end_angle_ff       <= csr_pwdata[7:0];
            dars_pkg::REG_BASE_MARGIN:     base_margin_ff     <= csr_pwdata[3:0];
            dars_pkg::REG_SERVO_OFFSET:    servo_offset_ff    <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   // Register reads
   always_comb begin
      unique case (csr_idx)
         dars_pkg::REG_UPPER_ARM_LEN:   csr_prdata = 32'(upper_arm_len_ff);
         dars_pkg::REG_LOWER_ARM_LEN:   csr_prdata = 32'(lower_arm_len_ff);
         dars_pkg::REG_BASE_RADIUS:     csr_prdata = 32'(base_radius_ff);
         dars_pkg::REG_EFFECTOR_RADIUS: csr_prdata = 32'(effector_radius_ff);
         dars_pkg::REG_START_ANGLE:     csr_prdata = {24'd0, start_angle_ff};
         dars_pkg::REG_END_ANGLE:       csr_prdata = {24'd0, end_angle_ff};
         dars_pkg::REG_BASE_MARGIN:     csr_prdata = 32'(base_margin_ff);
         dars_pkg::REG_SERVO_OFFSET:    csr_prdata = 32'(servo_offset_ff);
         default:                       csr_prdata = 32'd0;
      endcase
   end

   dars_pkg::dars_cmd_type    cmd;
   dars_pkg::dars_status_type status;
   logic [PASS_W-1:0]         issue_pass;

   dars_ctrl #(
      .NUM_PASSES (NUM_PASSES)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .start_angle (start_angle_ff),
      .end_angle   (end_angle_ff),
      .status      (status),
      .cmd         (cmd),
      .issue_pass  (issue_pass)
   );

   dars_datapath #(
      .NUM_PASSES (NUM_PASSES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .issue_pass      (issue_pass),
      .status          (status),
      .target_x        (req_target_x),
      .target_y        (req_target_y),
      .target_z        (req_target_z),
      .upper_arm_len   (upper_arm_len_ff),
      .lower_arm_len   (lower_arm_len_ff),
      .base_radius     (base_radius_ff),
      .effector_radius (effector_radius_ff),
      .base_margin     (base_margin_ff),
      .servo_offset    (servo_offset_ff),
      .angle_arm1      (rsp_angle_arm1),
      .angle_arm2      (rsp_angle_arm2),
      .angle_arm3      (rsp_angle_arm3),
      .found_arm1      (rsp_found_arm1),
      .found_arm2      (rsp_found_arm2),
      .found_arm3      (rsp_found_arm3),
      .servo_cmd1      (rsp_servo_cmd1),
      .servo_cmd2      (rsp_servo_cmd2),
      .servo_cmd3      (rsp_servo_cmd3)
   );

endmodule
`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for the delta arm angle search block.
`timescale 1ns / 1ps
module testbench;

   localparam int  PASSES     = 4;
   localparam int  FRAC       = 14;
   localparam int  CYCLE_LIMIT = 6000000;

   typedef struct {
      logic signed [10:0] x;
      logic signed [10:0] y;
      logic signed [10:0] z;
   } target_type;

   typedef struct {
      logic signed [7:0] angle [3];
      logic              found [3];
      logic [7:0]        servo [3];
   } pose_type;

   typedef struct {
      int upper;
      int lower;
      int base_r;
      int eff_r;
      int first_ang;
      int stop_ang;
      int margin;
      int offset;
   } geometry_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [10:0] req_target_x = '0;
   logic signed [10:0] req_target_y = '0;
   logic signed [10:0] req_target_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [7:0] rsp_angle_arm1, rsp_angle_arm2, rsp_angle_arm3;
   logic rsp_found_arm1, rsp_found_arm2, rsp_found_arm3;
   logic [7:0] rsp_servo_cmd1, rsp_servo_cmd2, rsp_servo_cmd3;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [4:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   target_type   pending_targets [$];
   pose_type     expected_poses [$];
   geometry_type geo;
   longint       sine_quarter [0:90];
   int           error_count = 0;
   int           cycle_count = 0;
   int           send_gap = 0;
   int           recv_wait = 0;
   bit           burst_mode = 1'b0;
   logic         req_taken = 1'b0;
   logic         rsp_taken = 1'b0;

   delta_arm_angle_search DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_target_x(req_target_x), .req_target_y(req_target_y),
      .req_target_z(req_target_z),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_angle_arm1(rsp_angle_arm1), .rsp_angle_arm2(rsp_angle_arm2),
      .rsp_angle_arm3(rsp_angle_arm3),
      .rsp_found_arm1(rsp_found_arm1), .rsp_found_arm2(rsp_found_arm2),
      .rsp_found_arm3(rsp_found_arm3),
      .rsp_servo_cmd1(rsp_servo_cmd1), .rsp_servo_cmd2(rsp_servo_cmd2),
      .rsp_servo_cmd3(rsp_servo_cmd3),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // Clock, 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Build the quarter-wave sine values from a Taylor series at 30 fraction bits
   function automatic void fill_sine_quarter();
      longint x, term, sum;
      for (int d = 0; d <= 90; d++) begin
         x    = (longint'(d) * 64'sd3373259426 + 64'sd90) / 180;
         term = x;
         sum  = x;
         for (int k = 1; k < 24 && term != 0; k++) begin
            term = (term * x) >>> 30;
            term = (term * x) >>> 30;
            term = term / (longint'(2 * k) * (2 * k + 1));
            if (k % 2 == 1) sum = sum - term;
            else sum = sum + term;
         end
         if (sum < 0) sum = 0;
         if (sum > (64'sd1 <<< 30)) sum = 64'sd1 <<< 30;
         sine_quarter[d] = (sum + (64'sd1 <<< (30 - FRAC - 1))) >>> (30 - FRAC);
      end
   endfunction

   function automatic longint sine_of(int deg);
      int r;
      r = deg % 360;
      if (r < 0) r += 360;
      if (r <= 90) return sine_quarter[r];
      if (r <= 180) return sine_quarter[180 - r];
      if (r <= 270) return -sine_quarter[r - 180];
      return -sine_quarter[360 - r];
   endfunction

   function automatic longint toward_zero(longint v, int sh);
      return v >= 0 ? (v >>> sh) : -((-v) >>> sh);
   endfunction

   // Digit-by-digit integer square root, rounded down
   function automatic longint floor_root(longint n);
      longint r, b, v;
      r = 0;
      v = n;
      b = 64'sd1 <<< 62;
      while (b > v) b = b >>> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - r - b;
            r = (r >>> 1) + b;
         end else begin
            r = r >>> 1;
         end
         b = b >>> 2;
      end
      return r;
   endfunction

   // Search one arm for the first angle whose elbow-to-target distance fits
   function automatic bit search_arm(longint ux, longint uy, longint tx, longint ty,
                                     longint tz, output int ang);
      longint one, px, py, sx, sy, c, s, ex, ey, ez, dx, dy, dz, d, m;
      one = 64'sd1 <<< FRAC;
      px  = toward_zero(tx * one + ux * geo.eff_r, FRAC);
      py  = toward_zero(ty * one + uy * geo.eff_r, FRAC);
      sx  = toward_zero(ux * geo.base_r, FRAC);
      sy  = toward_zero(uy * geo.base_r, FRAC);
      for (int j = 0; j < PASSES; j++) begin
         m = geo.margin + j;
         for (int a = geo.first_ang; a < geo.stop_ang; a++) begin
            c  = sine_of(a + 90);
            s  = sine_of(a);
            ex = toward_zero(sx * one * one + ux * geo.upper * c, 2 * FRAC);
            ey = toward_zero(sy * one * one + uy * geo.upper * c, 2 * FRAC);
            ez = toward_zero(geo.upper * s, FRAC);
            dx = px - ex;
            dy = py - ey;
            dz = tz - ez;
            d  = floor_root(dx * dx + dy * dy + dz * dz);
            if (d - m < geo.lower && d + m > geo.lower) begin
               ang = a;
               return 1'b1;
            end
         end
      end
      ang = 0;
      return 1'b0;
   endfunction

   function automatic pose_type predict_pose(target_type t);
      pose_type p;
      longint   ux [3];
      longint   uy [3];
      int       ang, cmd;
      bit       hit;
      ux[0] = 64'sd1 <<< FRAC;  uy[0] = 0;
      ux[1] = -sine_of(30);     uy[1] = sine_of(60);
      ux[2] = -sine_of(30);     uy[2] = -sine_of(60);
      for (int k = 0; k < 3; k++) begin
         hit = search_arm(ux[k], uy[k], t.x, t.y, t.z, ang);
         cmd = geo.offset - ang;
         if (cmd < 0) cmd = 0;
         if (cmd > 180) cmd = 180;
         p.angle[k] = ang[7:0];
         p.found[k] = hit;
         p.servo[k] = cmd[7:0];
      end
      return p;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      error_count++;
      if (error_count <= 40)
         $display("MISMATCH at cycle %0d: %s got %0d expected %0d",
                  cycle_count, what, got, want);
   endtask

   // Cycle counter and timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Monitor: predict on accepted requests, check accepted responses
   always @(posedge clock) begin
      pose_type want;
      logic signed [7:0] got_ang [3];
      logic              got_fnd [3];
      logic [7:0]        got_srv [3];
      target_type        t;
      req_taken <= req_valid && !req_stall && !reset;
      rsp_taken <= rsp_valid && !rsp_stall && !reset;
      if (!reset && req_valid && !req_stall) begin
         t.x = req_target_x;
         t.y = req_target_y;
         t.z = req_target_z;
         expected_poses.push_back(predict_pose(t));
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_poses.size() == 0) begin
            report_mismatch("unexpected transaction", 1, 0);
         end else begin
            want = expected_poses.pop_front();
            got_ang = '{rsp_angle_arm1, rsp_angle_arm2, rsp_angle_arm3};
            got_fnd = '{rsp_found_arm1, rsp_found_arm2, rsp_found_arm3};
            got_srv = '{rsp_servo_cmd1, rsp_servo_cmd2, rsp_servo_cmd3};
            for (int k = 0; k < 3; k++) begin
               if (got_ang[k] !== want.angle[k])
                  report_mismatch($sformatf("angle_arm%0d", k + 1), got_ang[k], want.angle[k]);
               if (got_fnd[k] !== want.found[k])
                  report_mismatch($sformatf("found_arm%0d", k + 1), got_fnd[k], want.found[k]);
               if (got_srv[k] !== want.servo[k])
                  report_mismatch($sformatf("servo_cmd%0d", k + 1), got_srv[k], want.servo[k]);
            end
         end
      end
   end

   // Driver: hold a stalled transaction, otherwise idle a drawn gap and send the next one
   always @(negedge clock) begin
      logic       next_valid;
      target_type t;
      next_valid = req_valid;
      if (reset) begin
         next_valid = 1'b0;
      end else begin
         if (req_valid && req_taken) next_valid = 1'b0;
         if (!next_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_targets.size() > 0) begin
               t = pending_targets.pop_front();
               req_target_x <= t.x;
               req_target_y <= t.y;
               req_target_z <= t.z;
               next_valid = 1'b1;
               send_gap = burst_mode ? 0 : $urandom_range(0, 15);
            end
         end
      end
      req_valid <= next_valid;
   end

   // Receiver: after each transaction draw how long the next one is stalled once it shows
   always @(negedge clock) begin
      if (rsp_taken) recv_wait = burst_mode ? 0 : $urandom_range(0, 15);
      if (recv_wait > 0) begin
         rsp_stall <= 1'b1;
         if (rsp_valid) recv_wait--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic csr_write(dars_pkg::dars_reg_type idx, int value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= 5'(idx) << 2;
      csr_pwdata  <= 32'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_geometry(int u, int l, int b, int e, int a0, int a1, int m, int o);
      csr_write(dars_pkg::REG_UPPER_ARM_LEN, u);
      csr_write(dars_pkg::REG_LOWER_ARM_LEN, l);
      csr_write(dars_pkg::REG_BASE_RADIUS, b);
      csr_write(dars_pkg::REG_EFFECTOR_RADIUS, e);
      csr_write(dars_pkg::REG_START_ANGLE, a0 & 8'hFF);
      csr_write(dars_pkg::REG_END_ANGLE, a1 & 8'hFF);
      csr_write(dars_pkg::REG_BASE_MARGIN, m);
      csr_write(dars_pkg::REG_SERVO_OFFSET, o);
      geo = '{u, l, b, e, a0, a1, m, o};
   endtask

   task automatic queue_target(int x, int y, int z);
      target_type t;
      t.x = 11'(x);
      t.y = 11'(y);
      t.z = 11'(z);
      pending_targets.push_back(t);
   endtask

   // Mostly targets within reach of the arms, the rest anywhere in the field range
   task automatic queue_random(int count);
      int reach, zlo, zhi;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) < 7) begin
            reach = geo.lower / 2 + 10;
            zlo = geo.lower / 2;
            zhi = geo.lower + geo.upper;
            if (zhi > 1023) zhi = 1023;
            queue_target(int'($urandom_range(0, 2 * reach)) - reach,
                         int'($urandom_range(0, 2 * reach)) - reach,
                         int'($urandom_range(zlo, zhi)));
         end else begin
            queue_target(int'($urandom_range(0, 2047)) - 1024,
                         int'($urandom_range(0, 2047)) - 1024,
                         int'($urandom_range(0, 2047)) - 1024);
         end
      end
   endtask

   // Wait until all results are back and the block is idle
   task automatic drain();
      while (pending_targets.size() != 0 || req_valid || expected_poses.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      int a0;
      fill_sine_quarter();
      geo = '{50, 210, 100, 35, -30, 80, 1, 105};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: directed targets
      queue_target(0, 0, 200);
      queue_target(0, 0, 180);
      queue_target(0, 0, 230);
      queue_target(1023, 1023, 1023);
      queue_target(-1024, -1024, -1024);
      queue_target(0, 0, 0);
      queue_target(1023, -1024, 0);
      queue_target(-1024, 1023, 1023);
      queue_target(50, -50, 200);
      queue_target(-60, 30, 210);
      queue_target(0, 0, -200);
      queue_target(100, 0, 190);
      queue_target(0, 100, 190);
      queue_target(-100, -100, 170);
      queue_target(0, 0, 150);
      queue_random(120);
      drain();

      // Largest geometry, full angle range, widest margin, top offset
      set_geometry(255, 511, 255, 255, -90, 90, 15, 180);
      queue_target(0, 0, 500);
      queue_target(-1024, 1023, -1024);
      queue_random(12);
      drain();

      // Smallest geometry with an empty range
      set_geometry(1, 1, 0, 0, 90, -90, 0, 0);
      queue_target(0, 0, 0);
      queue_target(1023, 1023, 1023);
      queue_random(20);
      drain();

      // Zero margin and zero offset on a normal geometry
      set_geometry(60, 200, 90, 30, -20, 30, 0, 0);
      queue_target(0, 0, 220);
      queue_random(60);
      drain();

      // Random geometries with short angle spans, some without idling
      for (int p = 0; p < 8; p++) begin
         burst_mode = (p % 3 == 1);
         a0 = int'($urandom_range(0, 150)) - 90;
         set_geometry($urandom_range(20, 150), $urandom_range(100, 400),
                      $urandom_range(0, 255), $urandom_range(0, 255), a0,
                      (a0 + int'($urandom_range(1, 40)) > 90) ? 90
                         : a0 + int'($urandom_range(1, 40)),
                      $urandom_range(0, 15), $urandom_range(0, 180));
         queue_random(80);
         drain();
      end

      repeat (50) @(posedge clock);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

### delta_arm_angle_search.f
rtl/dars_pkg.sv
rtl/dars_datapath.sv
rtl/dars_ctrl.sv
rtl/delta_arm_angle_search.sv
sim/testbench.sv
